### hdl/sprite_animation_sequencer_assert.svh
// Assertion macros shared by the sprite animation sequencer modules.
`ifndef SPRITE_ANIMATION_SEQUENCER_ASSERT_SVH
`define SPRITE_ANIMATION_SEQUENCER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SAS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sprite sequencer check failed");

// Consequent must hold in the cycle after the antecedent.
`define SAS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sprite sequencer check failed");

`endif

### hdl/sas_pkg.sv
// Types, constants and helper functions of the sprite animation sequencer.
package sas_pkg;

  // Field widths.
  localparam int CMD_W      = 2;
  localparam int TIME_W     = 24;
  localparam int ANIM_W     = 4;
  localparam int COORD_W    = 10;
  localparam int COUNT_W    = 5;
  localparam int FRAME_W    = 11;
  localparam int X_W        = 20;
  localparam int Y_W        = 21;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 10;

  localparam logic [TIME_W-1:0] TIME_MAX = '1;

  // Divider runs two quotient bits a cycle.
  localparam int DIV_CNT_W = 4;
  localparam logic [DIV_CNT_W-1:0] DIV_STEPS_TICK  = 4'd12;
  localparam logic [DIV_CNT_W-1:0] DIV_STEPS_COORD = 4'd6;

  // Request codes.
  typedef enum logic [CMD_W-1:0] {
    CMD_TICK   = 2'd0,
    CMD_SELECT = 2'd1,
    CMD_WRITE  = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_code_t;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAMES_PER_ROW = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ANIM_COUNT     = 2'd3;

  // Configuration reset values.
  localparam logic [COORD_W-1:0] RST_FRAME_WIDTH    = 10'd16;
  localparam logic [COORD_W-1:0] RST_FRAME_HEIGHT   = 10'd16;
  localparam logic [COORD_W-1:0] RST_FRAMES_PER_ROW = 10'd1;
  localparam logic [COUNT_W-1:0] RST_ANIM_COUNT     = 5'd1;

  // One animation table entry.
  typedef struct packed {
    logic [COORD_W-1:0] start;
    logic [COORD_W-1:0] length;
    logic [TIME_W-1:0]  delay;
  } anim_entry_t;

  // One input request.
  typedef struct packed {
    logic [CMD_W-1:0]   command;
    logic [TIME_W-1:0]  time_step;
    logic [ANIM_W-1:0]  anim_index;
    logic               loop_flag;
    logic [COORD_W-1:0] entry_start;
    logic [COORD_W-1:0] entry_length;
    logic [TIME_W-1:0]  entry_delay;
  } in_item_t;

  // Which animation index addresses the table read.
  typedef enum logic [1:0] {
    SEL_PLAYING = 2'd0,
    SEL_DEFAULT = 2'd1,
    SEL_INDEX   = 2'd2
  } rd_sel_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    load_item;
    logic    rd_en;
    rd_sel_t rd_sel;
    logic    tbl_write;
    logic    tick_check;
    logic    tick_apply;
    logic    anim_load;
    logic    coord_start;
    logic    out_load;
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    cmd_code_t command;
    logic      no_advance;
    logic      div_busy;
    logic      restart;
  } dp_status_t;

  // Divider working state: partial remainder and dividend/quotient shifter.
  typedef struct packed {
    logic [TIME_W-1:0] rem;
    logic [TIME_W-1:0] quo;
  } div_state_t;

  // One restoring division step.
  function automatic div_state_t div_step(input div_state_t cur,
                                          input logic [TIME_W-1:0] den);
    logic [TIME_W+1:0] diff;
    div_state_t        res;
    diff = {1'b0, cur.rem, cur.quo[TIME_W-1]} - {2'b00, den};
    if (!diff[TIME_W+1]) begin
      res.rem = diff[TIME_W-1:0];
    end else begin
      res.rem = {cur.rem[TIME_W-2:0], cur.quo[TIME_W-1]};
    end
    res.quo = {cur.quo[TIME_W-2:0], ~diff[TIME_W+1]};
    return res;
  endfunction

endpackage

### hdl/sas_in_if.sv
// Request channel of the sprite animation sequencer.
interface sas_in_if import sas_pkg::*;;
  logic               valid;
  logic               ready;
  logic [CMD_W-1:0]   command;
  logic [TIME_W-1:0]  time_step;
  logic [ANIM_W-1:0]  anim_index;
  logic               loop_flag;
  logic [COORD_W-1:0] entry_start;
  logic [COORD_W-1:0] entry_length;
  logic [TIME_W-1:0]  entry_delay;

  modport source (output valid, command, time_step, anim_index, loop_flag,
                  entry_start, entry_length, entry_delay, input ready);
  modport sink (input valid, command, time_step, anim_index, loop_flag,
                entry_start, entry_length, entry_delay, output ready);
endinterface

### hdl/sas_out_if.sv
// Result channel of the sprite animation sequencer.
interface sas_out_if import sas_pkg::*;;
  logic               valid;
  logic               ready;
  logic [FRAME_W-1:0] current_frame;
  logic [ANIM_W-1:0]  current_anim;
  logic [X_W-1:0]     source_x;
  logic [Y_W-1:0]     source_y;

  modport source (output valid, current_frame, current_anim, source_x, source_y,
                  input ready);
  modport sink (input valid, current_frame, current_anim, source_x, source_y,
                output ready);
endinterface

### hdl/sas_cfg_if.sv
// Configuration write channel of the sprite animation sequencer.
interface sas_cfg_if import sas_pkg::*;;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

### hdl/sas_ram.sv
// Generic single-write, single-read RAM with registered read data.
module sas_ram #(
  parameter int DATA_W = 8,
  parameter int DEPTH  = 16,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [AW-1:0]     waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic              re,
  input  logic [AW-1:0]     raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem_r [DEPTH];
  logic [DATA_W-1:0] rdata_r;

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### hdl/sas_ctrl.sv
// Controller state machine of the sprite animation sequencer.
`include "sprite_animation_sequencer_assert.svh"

module sas_ctrl import sas_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       out_ready,
  output logic       out_valid,
  input  dp_status_t status,
  output ctrl_cmd_t  cmd
);

  typedef enum logic [9:0] {
    ST_IDLE       = 10'b00_0000_0001,
    ST_DISPATCH   = 10'b00_0000_0010,
    ST_TICK_CHK   = 10'b00_0000_0100,
    ST_TICK_DIV   = 10'b00_0000_1000,
    ST_TICK_APPLY = 10'b00_0001_0000,
    ST_LOAD_DATA  = 10'b00_0010_0000,
    ST_COORD      = 10'b00_0100_0000,
    ST_COORD_DIV  = 10'b00_1000_0000,
    ST_OUT        = 10'b01_0000_0000,
    ST_SPARE      = 10'b10_0000_0000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;

  // Next-state and command decode.
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load_item = 1'b1;
          state_nxt     = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        case (status.command)
          CMD_TICK: begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = SEL_PLAYING;
            state_nxt  = ST_TICK_CHK;
          end
          CMD_SELECT: begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = SEL_INDEX;
            state_nxt  = ST_LOAD_DATA;
          end
          CMD_WRITE: begin
            cmd.tbl_write = 1'b1;
            state_nxt     = ST_COORD;
          end
          default: begin
            state_nxt = ST_COORD;
          end
        endcase
      end
      ST_TICK_CHK: begin
        cmd.tick_check = 1'b1;
        state_nxt      = status.no_advance ? ST_COORD : ST_TICK_DIV;
      end
      ST_TICK_DIV: begin
        if (!status.div_busy) begin
          state_nxt = ST_TICK_APPLY;
        end
      end
      ST_TICK_APPLY: begin
        cmd.tick_apply = 1'b1;
        if (status.restart) begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = SEL_DEFAULT;
          state_nxt  = ST_LOAD_DATA;
        end else begin
          state_nxt = ST_COORD;
        end
      end
      ST_LOAD_DATA: begin
        cmd.anim_load = 1'b1;
        state_nxt     = ST_COORD;
      end
      ST_COORD: begin
        cmd.coord_start = 1'b1;
        state_nxt       = ST_COORD_DIV;
      end
      ST_COORD_DIV: begin
        if (!status.div_busy) begin
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Output valid flag: set on load, cleared when the result is taken.
  always_comb begin
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Only one request is in flight at a time.
  `SAS_ASSERT_NEXT(a_single_request, clk, rst_n, in_valid && in_ready, !in_ready)
  // A waiting result is never overwritten.
  `SAS_ASSERT_NOW(a_out_hold, clk, rst_n, out_valid && !out_ready, !cmd.out_load)
  // The table is never read and written in the same cycle.
  `SAS_ASSERT_NOW(a_rd_wr_apart, clk, rst_n, cmd.rd_en, !cmd.tbl_write)

endmodule

### hdl/sas_datapath.sv
// Datapath of the sprite animation sequencer: table, timing state, divider, outputs.
`include "sprite_animation_sequencer_assert.svh"

module sas_datapath import sas_pkg::*; #(
  parameter int MAX_ANIMS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  in_item_t              in_item,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  ctrl_cmd_t             cmd,
  output dp_status_t            status,
  output logic [FRAME_W-1:0]    out_frame,
  output logic [ANIM_W-1:0]     out_anim,
  output logic [X_W-1:0]        out_x,
  output logic [Y_W-1:0]        out_y
);

  localparam int AW      = (MAX_ANIMS > 1) ? $clog2(MAX_ANIMS) : 1;
  localparam int ENTRY_W = $bits(anim_entry_t);

  // Configuration registers.
  logic [COORD_W-1:0] fw_r, fh_r, fpr_r;
  logic [COUNT_W-1:0] acnt_r;

  // Sequencer state.
  logic [ANIM_W-1:0]    playing_r, default_r;
  logic [FRAME_W-1:0]   frame_r;
  logic [TIME_W-1:0]    time_r;
  logic [MAX_ANIMS-1:0] valid_r;

  // Captured request.
  cmd_code_t          item_cmd_r;
  logic [ANIM_W-1:0]  item_idx_r;
  logic               item_loop_r;
  anim_entry_t        item_entry_r;
  logic [TIME_W-1:0]  t_r;

  // Table read and tick bookkeeping.
  logic [ANIM_W-1:0]  sel_idx_r;
  logic               rd_valid_r;
  logic [FRAME_W-1:0] end_r;

  // Shared divider.
  div_state_t           div_r;
  logic [TIME_W-1:0]    den_r;
  logic [DIV_CNT_W-1:0] div_cnt_r;

  // Result registers.
  logic [FRAME_W-1:0] out_frame_r;
  logic [ANIM_W-1:0]  out_anim_r;
  logic [X_W-1:0]     out_x_r;
  logic [Y_W-1:0]     out_y_r;

  // Combinational nets.
  logic [TIME_W:0]     time_sum;
  logic [TIME_W-1:0]   t_sat;
  logic [ENTRY_W-1:0]  rd_data;
  anim_entry_t         entry;
  logic [TIME_W-1:0]   delay_eff;
  logic [FRAME_W-1:0]  end_sum;
  logic [FRAME_W-1:0]  to_end;
  logic                restart;
  logic                no_advance;
  logic [COORD_W-1:0]  per_row;
  logic [ANIM_W-1:0]   rd_idx;
  logic [AW+ANIM_W-1:0] rd_idx_ext, wr_idx_ext;
  logic [AW-1:0]       rd_addr, wr_addr;
  logic                wr_ok, tbl_we;
  logic                make_default;
  div_state_t          div_s1, div_s2;
  logic [X_W-1:0]      x_prod;
  logic [Y_W-1:0]      y_prod;

  // Index clamp: out of range selects animation zero.
  function automatic logic [ANIM_W-1:0] clamp_idx(input logic [ANIM_W-1:0] idx,
                                                  input logic [COUNT_W-1:0] cnt);
    logic ok;
    ok = ({1'b0, idx} < cnt) && (32'(idx) < MAX_ANIMS);
    return ok ? idx : '0;
  endfunction

  // Saturating time accumulation for a tick.
  assign time_sum = {1'b0, time_r} + {1'b0, in_item.time_step};
  assign t_sat    = time_sum[TIME_W] ? TIME_MAX : time_sum[TIME_W-1:0];

  // Table entry as read; an entry never written reads as zero.
  assign entry     = rd_valid_r ? anim_entry_t'(rd_data) : '0;
  assign delay_eff = (entry.delay == '0) ? TIME_W'(1) : entry.delay;
  assign end_sum   = {1'b0, entry.start} + {1'b0, entry.length};
  assign no_advance = (t_r <= delay_eff);

  // Frames left before the end of the playing animation.
  assign to_end  = (end_r > frame_r) ? (end_r - frame_r) : FRAME_W'(1);
  assign restart = (div_r.quo >= {{(TIME_W-FRAME_W){1'b0}}, to_end});

  assign per_row = (fpr_r == '0) ? COORD_W'(1) : fpr_r;

  // Table read address selection.
  always_comb begin
    case (cmd.rd_sel)
      SEL_PLAYING: rd_idx = clamp_idx(playing_r, acnt_r);
      SEL_DEFAULT: rd_idx = clamp_idx(default_r, acnt_r);
      SEL_INDEX:   rd_idx = clamp_idx(item_idx_r, acnt_r);
      default:     rd_idx = '0;
    endcase
  end

  assign rd_idx_ext = {{AW{1'b0}}, rd_idx};
  assign wr_idx_ext = {{AW{1'b0}}, item_idx_r};
  assign rd_addr    = rd_idx_ext[AW-1:0];
  assign wr_addr    = wr_idx_ext[AW-1:0];
  assign wr_ok      = (32'(item_idx_r) < MAX_ANIMS);
  assign tbl_we     = cmd.tbl_write && wr_ok;

  assign make_default = item_loop_r && (item_cmd_r == CMD_SELECT);

  // Two division steps per cycle.
  assign div_s1 = div_step(div_r, den_r);
  assign div_s2 = div_step(div_s1, den_r);

  // Frame corner in the sheet.
  assign x_prod = X_W'(fw_r) * X_W'(div_r.rem[COORD_W-1:0]);
  assign y_prod = Y_W'(fh_r) * Y_W'(div_r.quo[FRAME_W-1:0]);

  sas_ram #(
    .DATA_W (ENTRY_W),
    .DEPTH  (MAX_ANIMS)
  ) u_anim_table (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (wr_addr),
    .wdata (item_entry_r),
    .re    (cmd.rd_en),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fw_r   <= RST_FRAME_WIDTH;
      fh_r   <= RST_FRAME_HEIGHT;
      fpr_r  <= RST_FRAMES_PER_ROW;
      acnt_r <= RST_ANIM_COUNT;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_FRAME_WIDTH:    fw_r   <= cfg_data;
        CFG_FRAME_HEIGHT:   fh_r   <= cfg_data;
        CFG_FRAMES_PER_ROW: fpr_r  <= cfg_data;
        CFG_ANIM_COUNT:     acnt_r <= cfg_data[COUNT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Sequencer state and divider step count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      playing_r <= '0;
      default_r <= '0;
      frame_r   <= '0;
      time_r    <= '0;
      valid_r   <= '0;
      div_cnt_r <= '0;
    end else begin
      if (tbl_we) begin
        valid_r[wr_addr] <= 1'b1;
      end
      if (cmd.tick_check) begin
        time_r <= t_r;
      end
      if (cmd.tick_apply && !restart) begin
        frame_r <= frame_r + div_r.quo[FRAME_W-1:0];
        time_r  <= div_r.rem + TIME_W'(1);
      end
      if (cmd.anim_load) begin
        playing_r <= sel_idx_r;
        if (make_default) begin
          default_r <= sel_idx_r;
        end
        frame_r <= {1'b0, entry.start};
        time_r  <= '0;
      end
      if (cmd.tick_check && !no_advance) begin
        div_cnt_r <= DIV_STEPS_TICK;
      end else if (cmd.coord_start) begin
        div_cnt_r <= DIV_STEPS_COORD;
      end else if (div_cnt_r != '0) begin
        div_cnt_r <= div_cnt_r - DIV_CNT_W'(1);
      end
    end
  end

  // Request capture, read bookkeeping, divider data and result registers.
  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      item_cmd_r   <= cmd_code_t'(in_item.command);
      item_idx_r   <= in_item.anim_index;
      item_loop_r  <= in_item.loop_flag;
      item_entry_r <= '{start: in_item.entry_start, length: in_item.entry_length,
                        delay: in_item.entry_delay};
      t_r          <= t_sat;
    end
    if (cmd.rd_en) begin
      sel_idx_r  <= rd_idx;
      rd_valid_r <= valid_r[rd_addr];
    end
    if (cmd.tick_check) begin
      end_r <= end_sum;
    end
    if (cmd.tick_check && !no_advance) begin
      // Advances are (t - 1) / delay; the remainder plus one is the time left.
      div_r.rem <= '0;
      div_r.quo <= t_r - TIME_W'(1);
      den_r     <= delay_eff;
    end else if (cmd.coord_start) begin
      div_r.rem <= '0;
      div_r.quo <= {1'b0, frame_r, {(TIME_W/2){1'b0}}};
      den_r     <= {{(TIME_W-COORD_W){1'b0}}, per_row};
    end else if (div_cnt_r != '0) begin
      div_r <= div_s2;
    end
    if (cmd.out_load) begin
      out_frame_r <= frame_r;
      out_anim_r  <= playing_r;
      out_x_r     <= x_prod;
      out_y_r     <= y_prod;
    end
  end

  assign status.command    = item_cmd_r;
  assign status.no_advance = no_advance;
  assign status.div_busy   = (div_cnt_r != '0);
  assign status.restart    = restart;

  assign out_frame = out_frame_r;
  assign out_anim  = out_anim_r;
  assign out_x     = out_x_r;
  assign out_y     = out_y_r;

  // Divider results are only consumed once the division has finished.
  `SAS_ASSERT_NOW(a_div_done, clk, rst_n, cmd.tick_apply || cmd.out_load, div_cnt_r == '0)
  // A division is only started while the divider is idle.
  `SAS_ASSERT_NOW(a_div_idle_start, clk, rst_n, cmd.tick_check || cmd.coord_start, div_cnt_r == '0)
  // A partial advance always leaves some time in the accumulator.
  `SAS_ASSERT_NEXT(a_time_left, clk, rst_n, cmd.tick_apply && !restart, time_r != '0)

endmodule

### hdl/sprite_animation_sequencer.sv
// Sprite animation sequencer: keeps an animation table, plays the selected
// animation as time ticks and reports the current frame and its sheet corner.
// One request is worked on at a time; a new request is taken while the previous
// result still waits on the result channel. A tick that advances the frame runs
// the shared divider twice, once over the 24-bit time code and once over the
// frame number for the column and row; any other request runs it only for the
// column and row. The divider resolves two quotient bits a cycle. The table is
// cleared by per-entry valid bits at reset, so the block accepts requests from
// the first cycle after reset. Configuration is always ready and should be
// written only while the block is idle.
module sprite_animation_sequencer import sas_pkg::*; #(
  parameter int MAX_ANIMS = 16
) (
  input logic      clk,
  input logic      rst_n,
  sas_in_if.sink   in_ch,
  sas_out_if.source out_ch,
  sas_cfg_if.sink  cfg_ch
);

  ctrl_cmd_t  cmd;
  dp_status_t status;
  in_item_t   in_item;
  logic       in_ready;
  logic       out_valid;

  // Request payload gathered into one word.
  assign in_item = '{command: in_ch.command, time_step: in_ch.time_step,
                     anim_index: in_ch.anim_index, loop_flag: in_ch.loop_flag,
                     entry_start: in_ch.entry_start, entry_length: in_ch.entry_length,
                     entry_delay: in_ch.entry_delay};

  assign in_ch.ready  = in_ready;
  assign out_ch.valid = out_valid;
  assign cfg_ch.ready = 1'b1;

  sas_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ready),
    .out_ready (out_ch.ready),
    .out_valid (out_valid),
    .status    (status),
    .cmd       (cmd)
  );

  sas_datapath #(
    .MAX_ANIMS (MAX_ANIMS)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_item   (in_item),
    .cfg_we    (cfg_ch.valid),
    .cfg_index (cfg_ch.index),
    .cfg_data  (cfg_ch.data),
    .cmd       (cmd),
    .status    (status),
    .out_frame (out_ch.current_frame),
    .out_anim  (out_ch.current_anim),
    .out_x     (out_ch.source_x),
    .out_y     (out_ch.source_y)
  );

endmodule

### tb/sas_frame_checker.sv
// Frame checker: predicts the sequencer's answer to each request and compares it.
module sas_frame_checker import sas_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  sas_in_if    in_ch,
  sas_out_if   out_ch,
  sas_cfg_if   cfg_ch,
  output int   fault_count,
  output int   frames_pending,
  output int   frames_checked
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TBL_DEPTH = 16;

  // One answer of the block.
  typedef struct packed {
    logic [FRAME_W-1:0] frame;
    logic [ANIM_W-1:0]  anim;
    logic [X_W-1:0]     x;
    logic [Y_W-1:0]     y;
  } frame_pos_t;

  // Predicted sequencer state and register copies.
  anim_entry_t        anim_tbl [TBL_DEPTH];
  logic [ANIM_W-1:0]  playing;
  logic [ANIM_W-1:0]  fallback;
  logic [FRAME_W-1:0] frame;
  logic [TIME_W-1:0]  elapsed;
  logic [COORD_W-1:0] frame_w;
  logic [COORD_W-1:0] frame_h;
  logic [COORD_W-1:0] per_row_cfg;
  logic [COUNT_W-1:0] anim_count;

  frame_pos_t frames_due [$];
  int         faults    = 0;
  int         n_checked = 0;

  // An index outside the valid part of the table falls back to animation 0.
  function automatic logic [ANIM_W-1:0] legal_anim(input logic [ANIM_W-1:0] idx);
    return (idx < anim_count && idx < TBL_DEPTH) ? idx : '0;
  endfunction

  function automatic void restart_anim(input logic [ANIM_W-1:0] idx,
                                       input logic make_default);
    logic [ANIM_W-1:0] a;
    a       = legal_anim(idx);
    playing = a;
    if (make_default) begin
      fallback = a;
    end
    frame   = {1'b0, anim_tbl[a].start};
    elapsed = '0;
  endfunction

  // Accumulate time and step the frame once per whole delay exceeded.
  function automatic void advance_time(input logic [TIME_W-1:0] step);
    logic [TIME_W:0]   sum;
    logic [TIME_W-1:0] t;
    logic [TIME_W-1:0] d;
    logic [TIME_W-1:0] steps;
    logic [FRAME_W:0]  stop_frame;
    logic [FRAME_W:0]  room;
    logic [ANIM_W-1:0] a;
    sum     = {1'b0, elapsed} + {1'b0, step};
    t       = sum[TIME_W] ? TIME_MAX : sum[TIME_W-1:0];
    elapsed = t;
    a       = legal_anim(playing);
    d       = (anim_tbl[a].delay == '0) ? TIME_W'(1) : anim_tbl[a].delay;
    if (t > d) begin
      steps      = (t - TIME_W'(1)) / d;
      stop_frame = anim_tbl[a].start + anim_tbl[a].length;
      room       = (stop_frame > frame) ? stop_frame - frame : (FRAME_W+1)'(1);
      if (steps >= room) begin
        restart_anim(fallback, 1'b0);
      end else begin
        frame   = frame + steps[FRAME_W-1:0];
        elapsed = t - steps * d;
      end
    end
  endfunction

  // Work out the state change of one request and the answer that follows it.
  function automatic frame_pos_t apply_request(input in_item_t rq);
    frame_pos_t         res;
    logic [COORD_W-1:0] per_row;
    logic [FRAME_W-1:0] col;
    logic [FRAME_W-1:0] row;
    logic [31:0]        px;
    logic [31:0]        py;
    case (rq.command)
      CMD_TICK:   advance_time(rq.time_step);
      CMD_SELECT: restart_anim(rq.anim_index, rq.loop_flag);
      CMD_WRITE: begin
        if (rq.anim_index < TBL_DEPTH) begin
          anim_tbl[rq.anim_index] = '{start: rq.entry_start, length: rq.entry_length,
                                      delay: rq.entry_delay};
        end
      end
      default: ;
    endcase
    per_row   = (per_row_cfg == '0) ? COORD_W'(1) : per_row_cfg;
    col       = frame % per_row;
    row       = frame / per_row;
    px        = frame_w * col;
    py        = frame_h * row;
    res.frame = frame;
    res.anim  = playing;
    res.x     = px[X_W-1:0];
    res.y     = py[Y_W-1:0];
    return res;
  endfunction

  function automatic void note_fault(input string what, input logic have_want,
                                     input frame_pos_t want, input frame_pos_t got);
    faults++;
    if (faults <= 10) begin
      if (have_want) begin
        $display("[%0t] %s: expected frame=%0d anim=%0d x=%0d y=%0d, got frame=%0d anim=%0d x=%0d y=%0d",
                 $time, what, want.frame, want.anim, want.x, want.y,
                 got.frame, got.anim, got.x, got.y);
      end else begin
        $display("[%0t] %s: got frame=%0d anim=%0d x=%0d y=%0d",
                 $time, what, got.frame, got.anim, got.x, got.y);
      end
    end
  endfunction

  // Watch every handshake at the clock edge at which it completes.
  always @(posedge clk) begin : watch
    in_item_t   rq;
    frame_pos_t got;
    frame_pos_t want;
    if (!rst_n) begin
      for (int i = 0; i < TBL_DEPTH; i++) begin
        anim_tbl[i] = '0;
      end
      playing     = '0;
      fallback    = '0;
      frame       = '0;
      elapsed     = '0;
      frame_w     = RST_FRAME_WIDTH;
      frame_h     = RST_FRAME_HEIGHT;
      per_row_cfg = RST_FRAMES_PER_ROW;
      anim_count  = RST_ANIM_COUNT;
      frames_due.delete();
    end else begin
      // Register writes.
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_ch.index)
          CFG_FRAME_WIDTH:    frame_w     = cfg_ch.data;
          CFG_FRAME_HEIGHT:   frame_h     = cfg_ch.data;
          CFG_FRAMES_PER_ROW: per_row_cfg = cfg_ch.data;
          CFG_ANIM_COUNT:     anim_count  = cfg_ch.data[COUNT_W-1:0];
          default: ;
        endcase
      end

      // Results are matched before this edge's request is added, since a result
      // can never belong to a request taken at the same edge.
      if (out_ch.valid && out_ch.ready) begin
        got.frame = out_ch.current_frame;
        got.anim  = out_ch.current_anim;
        got.x     = out_ch.source_x;
        got.y     = out_ch.source_y;
        if (frames_due.size() == 0) begin
          note_fault("result with no request outstanding", 1'b0, got, got);
        end else begin
          want = frames_due.pop_front();
          n_checked++;
          if (got.frame !== want.frame || got.anim !== want.anim ||
              got.x !== want.x || got.y !== want.y) begin
            note_fault("result mismatch", 1'b1, want, got);
          end
        end
      end

      // Accepted requests.
      if (in_ch.valid && in_ch.ready) begin
        rq.command      = in_ch.command;
        rq.time_step    = in_ch.time_step;
        rq.anim_index   = in_ch.anim_index;
        rq.loop_flag    = in_ch.loop_flag;
        rq.entry_start  = in_ch.entry_start;
        rq.entry_length = in_ch.entry_length;
        rq.entry_delay  = in_ch.entry_delay;
        frames_due.push_back(apply_request(rq));
      end
    end
    fault_count    <= faults;
    frames_pending <= frames_due.size();
    frames_checked <= n_checked;
  end

endmodule

### tb/tb_sprite_animation_sequencer.sv
// Testbench top of the sprite animation sequencer: clock, reset, stimulus and verdict.
module tb_sprite_animation_sequencer;
  timeunit 1ns;
  timeprecision 1ps;
  import sas_pkg::*;

  localparam int          PHASES      = 6;
  localparam int          PHASE_ITEMS = 325;
  localparam int          SETTLE_GAP  = 40;
  localparam longint      RUN_LIMIT   = 8_000_000;

  logic clk = 1'b0;
  logic rst_n;

  sas_in_if  in_ch();
  sas_out_if out_ch();
  sas_cfg_if cfg_ch();

  int fault_count;
  int frames_pending;
  int frames_checked;

  // Stimulus bookkeeping, used to shape the requests and for the final report.
  int unsigned       send_idle = 0;
  int unsigned       recv_idle = 0;
  int unsigned       ac_known  = RST_ANIM_COUNT;
  logic [ANIM_W-1:0] playing_idx = '0;
  logic [TIME_W-1:0] shadow_delay [16] = '{default: '0};
  int                n_sent      = 0;
  int                n_directed  = 0;
  int                n_reg_writes = 0;
  int                n_settings  = 1;

  sprite_animation_sequencer #(.MAX_ANIMS(16)) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  sas_frame_checker frame_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_ch          (in_ch),
    .out_ch         (out_ch),
    .cfg_ch         (cfg_ch),
    .fault_count    (fault_count),
    .frames_pending (frames_pending),
    .frames_checked (frames_checked)
  );

  // 12 ns clock.
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // The result side stalls at random in the current proportion.
  always @(posedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= recv_idle);
  end

  function automatic in_item_t req(input cmd_code_t cmd, input logic [TIME_W-1:0] step,
                                   input logic [ANIM_W-1:0] idx, input logic loop,
                                   input logic [COORD_W-1:0] start,
                                   input logic [COORD_W-1:0] len,
                                   input logic [TIME_W-1:0] delay);
    in_item_t rq;
    rq.command      = cmd;
    rq.time_step    = step;
    rq.anim_index   = idx;
    rq.loop_flag    = loop;
    rq.entry_start  = start;
    rq.entry_length = len;
    rq.entry_delay  = delay;
    return rq;
  endfunction

  // Time steps mostly of a few delays of the animation thought to be playing.
  function automatic logic [TIME_W-1:0] tick_step();
    logic [TIME_W:0]   d;
    logic [TIME_W+2:0] s;
    d = (shadow_delay[playing_idx] == '0) ? 1 : shadow_delay[playing_idx];
    case ($urandom_range(19))
      0:       return '0;
      1:       return TIME_MAX;
      2:       return TIME_W'($urandom);
      default: begin
        s = d * $urandom_range(2) + $urandom_range(d);
        return (s > TIME_MAX) ? TIME_MAX : s[TIME_W-1:0];
      end
    endcase
  endfunction

  // A request of the given kind; fields it does not use carry random bits.
  function automatic in_item_t random_req(input cmd_code_t kind);
    in_item_t    rq;
    logic [95:0] noise;
    int unsigned span;
    noise      = {$urandom, $urandom, $urandom};
    rq         = noise[$bits(in_item_t)-1:0];
    rq.command = kind;
    span       = (ac_known == 0) ? 1 : ((ac_known > 16) ? 16 : ac_known);
    case (kind)
      CMD_TICK:   rq.time_step = tick_step();
      CMD_SELECT: begin
        if ($urandom_range(99) < 85) begin
          rq.anim_index = $urandom_range(span - 1);
        end
      end
      CMD_WRITE: begin
        if ($urandom_range(99) < 70) begin
          rq.anim_index = $urandom_range(span - 1);
        end
        case ($urandom_range(9))
          0:       rq.entry_start = '0;
          1:       rq.entry_start = '1;
          default: ;
        endcase
        if ($urandom_range(9) < 8) begin
          rq.entry_length = $urandom_range(8);
        end
        case ($urandom_range(19))
          0, 1:    rq.entry_delay = '0;
          2:       rq.entry_delay = TIME_MAX;
          3, 4:    ;
          5, 6, 7: rq.entry_delay = $urandom_range(3, 1);
          default: rq.entry_delay = $urandom_range(1024, 1);
        endcase
      end
      default: ;
    endcase
    return rq;
  endfunction

  // Present one request and hold it until it is taken. Valid stays high at the
  // accepting edge so that a following request can go out at once.
  task automatic send_req(input in_item_t rq);
    while ($urandom_range(99) < send_idle) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.command      <= rq.command;
    in_ch.time_step    <= rq.time_step;
    in_ch.anim_index   <= rq.anim_index;
    in_ch.loop_flag    <= rq.loop_flag;
    in_ch.entry_start  <= rq.entry_start;
    in_ch.entry_length <= rq.entry_length;
    in_ch.entry_delay  <= rq.entry_delay;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    n_sent++;
    if (rq.command == CMD_WRITE) begin
      shadow_delay[rq.anim_index] = rq.entry_delay;
    end else if (rq.command == CMD_SELECT) begin
      playing_idx = (rq.anim_index < ac_known) ? rq.anim_index : '0;
    end
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    n_reg_writes++;
  endtask

  // Stop sending and wait until every outstanding result has come back.
  task automatic settle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (frames_pending != 0) @(posedge clk);
    repeat (SETTLE_GAP) @(posedge clk);
  endtask

  // Rewrite all four registers while the block is idle.
  task automatic configure(input logic [CFG_DATA_W-1:0] fw, input logic [CFG_DATA_W-1:0] fh,
                           input logic [CFG_DATA_W-1:0] fpr,
                           input logic [CFG_DATA_W-1:0] acd);
    settle();
    write_reg(CFG_FRAME_WIDTH, fw);
    write_reg(CFG_FRAME_HEIGHT, fh);
    write_reg(CFG_FRAMES_PER_ROW, fpr);
    write_reg(CFG_ANIM_COUNT, acd);
    cfg_ch.valid <= 1'b0;
    ac_known = acd[COUNT_W-1:0];
    n_settings++;
  endtask

  // Run limit.
  initial begin
    #(RUN_LIMIT);
    $display("Timeout with %0d results outstanding.", frames_pending);
    $display("** sprite_animation_sequencer: FAILED **");
    $finish;
  end

  initial begin
    logic [CFG_DATA_W-1:0] fw;
    logic [CFG_DATA_W-1:0] fh;
    logic [CFG_DATA_W-1:0] fpr;
    logic [CFG_DATA_W-1:0] acd;
    int unsigned           pick;
    int                    phase_start;

    rst_n              <= 1'b0;
    in_ch.valid        <= 1'b0;
    in_ch.command      <= CMD_NONE;
    in_ch.time_step    <= '0;
    in_ch.anim_index   <= '0;
    in_ch.loop_flag    <= 1'b0;
    in_ch.entry_start  <= '0;
    in_ch.entry_length <= '0;
    in_ch.entry_delay  <= '0;
    cfg_ch.valid       <= 1'b0;
    cfg_ch.index       <= CFG_FRAME_WIDTH;
    cfg_ch.data        <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed requests with the reset settings: an empty table has zero delay
    // and zero length, so the first advance restarts at once.
    send_idle = 31;
    recv_idle = 71;
    send_req(req(CMD_TICK, '0, '0, 1'b0, '0, '0, '0));
    send_req(req(CMD_TICK, 24'd5, '0, 1'b0, '0, '0, '0));
    send_req(random_req(CMD_NONE));
    send_req(req(CMD_WRITE, '0, 4'd0, 1'b0, 10'd2, 10'd3, 24'h000100));
    send_req(req(CMD_WRITE, '0, 4'd15, 1'b0, '1, '1, TIME_MAX));
    send_req(req(CMD_SELECT, '0, 4'd0, 1'b1, '0, '0, '0));
    // Exactly one delay does not advance; one code more does.
    send_req(req(CMD_TICK, 24'h000100, '0, 1'b0, '0, '0, '0));
    send_req(req(CMD_TICK, 24'h000001, '0, 1'b0, '0, '0, '0));
    // Running past the end clears the time, so nothing more happens in this tick.
    send_req(req(CMD_TICK, 24'h000200, '0, 1'b0, '0, '0, '0));
    // Select beyond the valid entries falls back to animation 0.
    send_req(req(CMD_SELECT, '0, 4'd5, 1'b1, '0, '0, '0));
    send_req(req(CMD_TICK, TIME_MAX, '0, 1'b0, '0, '0, '0));

    // Largest frame sizes, zero frames per row and the whole table.
    configure(10'd1023, 10'd1023, 10'd0, 10'd16);
    send_req(req(CMD_SELECT, '0, 4'd15, 1'b1, '0, '0, '0));
    // The time saturates and never exceeds the largest delay.
    send_req(req(CMD_TICK, TIME_MAX, '0, 1'b0, '0, '0, '0));
    send_req(req(CMD_TICK, TIME_MAX, '0, 1'b0, '0, '0, '0));
    send_req(req(CMD_WRITE, '0, 4'd14, 1'b0, '1, '1, 24'h000001));
    send_req(req(CMD_SELECT, '0, 4'd14, 1'b0, '0, '0, '0));
    // Walk to the highest frame number.
    send_req(req(CMD_TICK, 24'd1023, '0, 1'b0, '0, '0, '0));
    // Shrink the playing entry so that the frame is already beyond its end.
    send_req(req(CMD_WRITE, '0, 4'd14, 1'b0, '0, 10'd5, 24'h000001));
    send_req(req(CMD_TICK, 24'd2, '0, 1'b0, '0, '0, '0));

    // Fewer valid entries: both the playing and the default animation are out
    // of range now, so the restart lands on animation 0.
    configure(10'd1, 10'd1, 10'd1023, 10'd4);
    send_req(req(CMD_TICK, TIME_MAX, '0, 1'b0, '0, '0, '0));
    send_req(req(CMD_SELECT, '0, 4'd3, 1'b0, '0, '0, '0));
    send_req(req(CMD_TICK, '0, '1, 1'b1, '1, '1, '1));
    n_directed = n_sent;

    // Random phases, each under its own settings and idling pattern.
    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: begin fw = 10'd16;   fh = 10'd16;   fpr = 10'd4;    acd = 10'd16; end
        1: begin fw = 10'd1023; fh = 10'd1;    fpr = 10'd1023; acd = 10'd5;  end
        2: begin fw = 10'd1;    fh = 10'd1023; fpr = 10'd0;    acd = 10'd16; end
        3: begin
          fw  = $urandom_range(1023, 1);
          fh  = $urandom_range(1023, 1);
          fpr = $urandom_range(12, 1);
          acd = $urandom_range(16, 1);
        end
        4: begin
          fw  = $urandom_range(1023, 1);
          fh  = $urandom_range(1023, 1);
          fpr = $urandom_range(1023);
          acd = $urandom_range(1023);
        end
        default: begin fw = 10'd3; fh = 10'd5; fpr = 10'd2; acd = 10'd1; end
      endcase
      configure(fw, fh, fpr, acd);
      send_idle = (ph < 2) ? 31 : ((ph < 4) ? 71 : 0);
      recv_idle = (ph < 2) ? 71 : ((ph < 4) ? 31 : 0);

      // Fill part of the table, pick an animation, then mostly let time run.
      phase_start = n_sent;
      repeat ($urandom_range(6, 3)) send_req(random_req(CMD_WRITE));
      send_req(random_req(CMD_SELECT));
      while (n_sent - phase_start < PHASE_ITEMS) begin
        pick = $urandom_range(99);
        if (pick < 62) begin
          send_req(random_req(CMD_TICK));
        end else if (pick < 76) begin
          send_req(random_req(CMD_SELECT));
        end else if (pick < 94) begin
          send_req(random_req(CMD_WRITE));
        end else begin
          send_req(random_req(CMD_NONE));
        end
      end
    end

    settle();
    $display("Run covered %0d requests (%0d directed) and %0d checked results,",
             n_sent, n_directed, frames_checked);
    $display("under %0d register settings written by %0d register writes.",
             n_settings, n_reg_writes);
    if (fault_count == 0 && frames_pending == 0) begin
      $display("** sprite_animation_sequencer: PASSED **");
    end else begin
      $display("** sprite_animation_sequencer: FAILED **");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+hdl
hdl/sas_pkg.sv
hdl/sas_in_if.sv
hdl/sas_out_if.sv
hdl/sas_cfg_if.sv
hdl/sas_ram.sv
hdl/sas_ctrl.sv
hdl/sas_datapath.sv
hdl/sprite_animation_sequencer.sv
tb/sas_frame_checker.sv
tb/tb_sprite_animation_sequencer.sv
